// ===== rtl/core/ray_segment_nearest_hit_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ray/segment nearest hit: assertion macros
// Shared property shorthands; the enclosing module provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef RAY_SEGMENT_NEAREST_HIT_TOP_DEFINES_SVH
`define RAY_SEGMENT_NEAREST_HIT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RSNH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define RSNH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rsnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rsnh_pkg
// Types and fixed constants of the ray/segment nearest hit block.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  // Coordinate format: signed Q16.8
  localparam int COORD_W    = 24;
  localparam int THRESH_W   = 23;
  localparam int DIST_W     = COORD_W + 1;
  // Squared distance of two coordinate differences, summed
  localparam int DIST_SQ_W  = 2 * COORD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd42;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_DIR_X     = 3'd2,
    CFG_DIR_Y     = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_reg_e;

  // One wall segment
  typedef struct packed {
    logic signed [COORD_W-1:0] wall_start_x;
    logic signed [COORD_W-1:0] wall_start_y;
    logic signed [COORD_W-1:0] wall_end_x;
    logic signed [COORD_W-1:0] wall_end_y;
    logic                      last_wall;
  } wall_item_t;

  // One ray result
  typedef struct packed {
    logic                      hit_found;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic [DIST_W-1:0]         hit_distance;
  } hit_item_t;

  // Shared divide / square root unit
  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_mode_e;

  typedef struct packed {
    logic     start;
    ds_mode_e mode;
  } ds_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DEN_A,
    ST_DEN_B,
    ST_TNUM_A,
    ST_TNUM_B,
    ST_U_A,
    ST_U_B,
    ST_CHECK,
    ST_DECIDE,
    ST_DIV,
    ST_HIT_X,
    ST_HIT_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_UPDATE,
    ST_FINISH,
    ST_ROOT,
    ST_EMIT
  } rsnh_state_e;

endpackage

// ===== rtl/core/rsnh_divsqrt.sv =====
// ----------------------------------------------------------------------------
// rsnh_divsqrt
// Restoring divider and integer square root sharing one subtractor.
// Divide: fractional quotient num/den with num < den, Q_W bits, one per cycle.
// Square root: floor root of a 2*ROOT_W bit radicand, one bit per cycle.
// ----------------------------------------------------------------------------
`include "ray_segment_nearest_hit_top_defines.svh"

module rsnh_divsqrt import rsnh_pkg::*; #(
  parameter int NUM_W  = 31,
  parameter int Q_W    = 16,
  parameter int ROOT_W = 25
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  ds_cmd_t                                     cmd_i,
  input  logic [NUM_W-1:0]                            num_i,
  input  logic [NUM_W-1:0]                            den_i,
  input  logic [2*ROOT_W-1:0]                         rad_i,
  output ds_stat_t                                    stat_o,
  output logic [((Q_W > ROOT_W) ? Q_W : ROOT_W)-1:0]  result_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int RES_W = (Q_W > ROOT_W) ? Q_W : ROOT_W;
  localparam int SUB_W = (NUM_W + 1 > ROOT_W + 2) ? NUM_W + 1 : ROOT_W + 2;
  localparam int CNT_W = $clog2(RES_W + 1);

  logic             busy_q, done_q;
  ds_mode_e         mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUB_W-1:0] rem_q;
  logic [RES_W-1:0] res_q;
  logic [RAD_W-1:0] rad_q;
  logic [NUM_W-1:0] dvs_q;

  logic [SUB_W-1:0] shifted, trial;
  logic [SUB_W:0]   diff;
  logic             fits;

  // Shared trial subtract
  always_comb begin
    if (mode_q == DS_DIV) begin
      shifted = {rem_q[SUB_W-2:0], 1'b0};
      trial   = SUB_W'(dvs_q);
    end else begin
      shifted = {rem_q[SUB_W-3:0], rad_q[RAD_W-1 -: 2]};
      trial   = SUB_W'({res_q[ROOT_W-1:0], 2'b01});
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    fits = ~diff[SUB_W];
  end

  // Step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= DS_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        mode_q <= cmd_i.mode;
        cnt_q  <= (cmd_i.mode == DS_DIV) ? CNT_W'(Q_W) : CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, result and operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= (cmd_i.mode == DS_DIV) ? SUB_W'(num_i) : '0;
      res_q <= '0;
      rad_q <= rad_i;
      dvs_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[SUB_W-1:0] : shifted;
      res_q <= {res_q[RES_W-2:0], fits};
      rad_q <= rad_q << 2;
    end
  end

  assign stat_o   = '{busy: busy_q, done: done_q};
  assign result_o = res_q;

  `RSNH_ASSERT_IMP(a_no_restart, cmd_i.start, !busy_q, "divsqrt started while busy")
  `RSNH_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q), "done without a running op")
  `RSNH_ASSERT_IMP(a_div_rem_bound, busy_q && mode_q == DS_DIV, rem_q < SUB_W'(dvs_q), "divide remainder not below divisor")

endmodule

// ===== rtl/core/ray_segment_nearest_hit_top.sv =====
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit_top
// Casts one configured ray against a stream of wall segments and reports the
// nearest hit point and its distance when the last segment of a list arrives.
// ----------------------------------------------------------------------------
// The block takes one segment at a time and is not ready while it works on
// it. Each segment uses one multiply per cycle on a single shared multiplier
// for the cross products; a hit adds the bit-serial divide that forms t in
// the shared divide/square root unit (skipped when t is exactly one) and
// the multiplies for the hit point and the squared distance. A segment
// marked last adds the bit-serial square root of the best squared distance
// when the ray has a hit (one root bit per cycle, 25 bits) and the hand-off
// of the result to the output register. The result register stays loaded
// until taken, and the block accepts the next segment meanwhile.
// Configuration writes are always taken, and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
`include "ray_segment_nearest_hit_top_defines.svh"

module ray_segment_nearest_hit_top import rsnh_pkg::*; #(
  parameter int DIR_FRAC_BITS = 14,
  parameter int T_FRAC_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // segment items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wall_item_t            in_item_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hit_item_t             out_item_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DIR_W   = DIR_FRAC_BITS + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DEN_W   = DIR_W + COORD_W + 1;
  localparam int U_W     = 2 * DIFF_W;
  localparam int TQ_W    = T_FRAC_BITS + 1;
  localparam int MUL_W0  = (DIFF_W > DIR_W) ? DIFF_W : DIR_W;
  localparam int MUL_W   = (MUL_W0 > TQ_W + 1) ? MUL_W0 : TQ_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int OFF_W   = TQ_W + DIFF_W + 2;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ROOT_W  = (DIST_SQ_W + 1) / 2;
  localparam int RES_W   = (T_FRAC_BITS > ROOT_W) ? T_FRAC_BITS : ROOT_W;

  localparam logic [TQ_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic signed [OFF_W-1:0] T_HALF =
    {{(OFF_W - T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS - 1){1'b0}}};

  rsnh_state_e state_q, state_d;

  // configuration
  logic signed [COORD_W-1:0] org_x_q, org_y_q;
  logic signed [DIR_W-1:0]   dir_x_q, dir_y_q;
  logic [THRESH_W-1:0]       thr_q;

  // captured segment
  logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic                      last_q;

  // working registers
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [DEN_W-1:0]   den_q, tnum_q;
  logic signed [U_W-1:0]     ud_q;
  logic [DEN_W-1:0]          den_mag_q, tnum_mag_q;
  logic                      den_low_q;
  logic [TQ_W-1:0]           tq_q;
  logic signed [COORD_W-1:0] hx_q, hy_q;
  logic [DIST_SQ_W-1:0]      dist_q;

  // per-ray state
  logic [DIST_SQ_W-1:0]      best_sq_q;
  logic signed [COORD_W-1:0] best_x_q, best_y_q;
  logic                      any_hit_q;

  // output register
  logic                      out_valid_q;
  hit_item_t                 out_item_q;

  logic signed [DIFF_W-1:0]  wx, wy, px, py, ex, ey, dhx, dhy;
  logic signed [MUL_W-1:0]   mul_a, mul_b, tq_s;
  logic signed [DEN_W-1:0]   prod_den;
  logic signed [U_W-1:0]     prod_u;
  logic signed [OFF_W-1:0]   off_sum, off_sh;
  logic signed [COORD_W-1:0] coord_base, hit_coord;
  logic                      seg_hit, t_one, out_load, in_acc;
  ds_cmd_t                   ds_cmd;
  ds_stat_t                  ds_stat;
  logic [RES_W-1:0]          ds_result;

  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Operand differences
  assign wx  = DIFF_W'(ax_q) - DIFF_W'(bx_q);
  assign wy  = DIFF_W'(ay_q) - DIFF_W'(by_q);
  assign px  = DIFF_W'(ax_q) - DIFF_W'(org_x_q);
  assign py  = DIFF_W'(ay_q) - DIFF_W'(org_y_q);
  assign ex  = DIFF_W'(bx_q) - DIFF_W'(ax_q);
  assign ey  = DIFF_W'(by_q) - DIFF_W'(ay_q);
  assign dhx = DIFF_W'(hx_q) - DIFF_W'(org_x_q);
  assign dhy = DIFF_W'(hy_q) - DIFF_W'(org_y_q);
  assign tq_s = MUL_W'($signed({1'b0, tq_q}));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DEN_A:  begin mul_a = MUL_W'(dir_x_q); mul_b = MUL_W'(wy);  end
      ST_DEN_B:  begin mul_a = MUL_W'(dir_y_q); mul_b = MUL_W'(wx);  end
      ST_TNUM_A: begin mul_a = MUL_W'(dir_x_q); mul_b = MUL_W'(py);  end
      ST_TNUM_B: begin mul_a = MUL_W'(dir_y_q); mul_b = MUL_W'(px);  end
      ST_U_A:    begin mul_a = MUL_W'(px);      mul_b = MUL_W'(wy);  end
      ST_U_B:    begin mul_a = MUL_W'(py);      mul_b = MUL_W'(wx);  end
      ST_HIT_X:  begin mul_a = tq_s;            mul_b = MUL_W'(ex);  end
      ST_HIT_Y:  begin mul_a = tq_s;            mul_b = MUL_W'(ey);  end
      ST_SQ_X:   begin mul_a = MUL_W'(dhx);     mul_b = MUL_W'(dhx); end
      ST_SQ_Y:   begin mul_a = MUL_W'(dhy);     mul_b = MUL_W'(dhy); end
      default:   begin mul_a = '0;              mul_b = '0;          end
    endcase
  end

  assign prod_den = $signed(prod_q[DEN_W-1:0]);
  assign prod_u   = $signed(prod_q[U_W-1:0]);

  // Hit coordinate: start + round(t * delta), halves up
  assign off_sum    = $signed({prod_q[OFF_W-2], prod_q[OFF_W-2:0]}) + T_HALF;
  assign off_sh     = off_sum >>> T_FRAC_BITS;
  assign coord_base = (state_q == ST_HIT_Y) ? ax_q : ay_q;
  assign hit_coord  = coord_base + off_sh[COORD_W-1:0];

  // Segment hit test
  always_comb begin
    seg_hit = !den_low_q;
    if (tnum_q != '0 && tnum_q[DEN_W-1] != den_q[DEN_W-1]) seg_hit = 1'b0;
    if (tnum_mag_q > den_mag_q) seg_hit = 1'b0;
    if (ud_q != '0 && ud_q[U_W-1] != den_q[DEN_W-1]) seg_hit = 1'b0;
    t_one = (tnum_mag_q == den_mag_q);
  end

  // Sequencer: next state and unit commands
  always_comb begin
    state_d     = state_q;
    ds_cmd      = '{start: 1'b0, mode: DS_DIV};
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_DEN_A;
      end
      ST_DEN_A:  state_d = ST_DEN_B;
      ST_DEN_B:  state_d = ST_TNUM_A;
      ST_TNUM_A: state_d = ST_TNUM_B;
      ST_TNUM_B: state_d = ST_U_A;
      ST_U_A:    state_d = ST_U_B;
      ST_U_B:    state_d = ST_CHECK;
      ST_CHECK:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!seg_hit) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end else if (t_one) begin
          state_d = ST_HIT_X;
        end else begin
          ds_cmd  = '{start: 1'b1, mode: DS_DIV};
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (ds_stat.done) state_d = ST_HIT_X;
      end
      ST_HIT_X:  state_d = ST_HIT_Y;
      ST_HIT_Y:  state_d = ST_SQ_X;
      ST_SQ_X:   state_d = ST_SQ_Y;
      ST_SQ_Y:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_UPDATE;
      ST_UPDATE: state_d = last_q ? ST_FINISH : ST_IDLE;
      ST_FINISH: begin
        if (any_hit_q) begin
          ds_cmd  = '{start: 1'b1, mode: DS_SQRT};
          state_d = ST_ROOT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_ROOT: begin
        if (ds_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      dir_x_q <= {2'b01, {DIR_FRAC_BITS{1'b0}}};
      dir_y_q <= '0;
      thr_q   <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:  org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:  org_y_q <= cfg_data_i;
        CFG_DIR_X:     dir_x_q <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Y:     dir_y_q <= cfg_data_i[DIR_W-1:0];
        CFG_THRESHOLD: thr_q   <= cfg_data_i[THRESH_W-1:0];
        default:       ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      ax_q   <= in_item_i.wall_start_x;
      ay_q   <= in_item_i.wall_start_y;
      bx_q   <= in_item_i.wall_end_x;
      by_q   <= in_item_i.wall_end_y;
      last_q <= in_item_i.last_wall;
    end
    case (state_q)
      ST_DEN_B:  den_q  <= prod_den;
      ST_TNUM_A: den_q  <= den_q - prod_den;
      ST_TNUM_B: tnum_q <= prod_den;
      ST_U_A: begin
        tnum_q    <= tnum_q - prod_den;
        den_mag_q <= den_q[DEN_W-1] ? -den_q : den_q;
      end
      ST_U_B:    ud_q <= prod_u;
      ST_CHECK: begin
        ud_q       <= ud_q - prod_u;
        tnum_mag_q <= tnum_q[DEN_W-1] ? -tnum_q : tnum_q;
        den_low_q  <= (den_mag_q == '0) || (den_mag_q < DEN_W'(thr_q));
      end
      ST_DECIDE: tq_q <= T_ONE;
      ST_DIV: begin
        if (ds_stat.done) tq_q <= TQ_W'(ds_result[T_FRAC_BITS-1:0]);
      end
      ST_HIT_Y:  hx_q   <= hit_coord;
      ST_SQ_X:   hy_q   <= hit_coord;
      ST_SQ_Y:   dist_q <= DIST_SQ_W'(prod_q[SQ_W-1:0]);
      ST_SUM:    dist_q <= dist_q + DIST_SQ_W'(prod_q[SQ_W-1:0]);
      default:   ;
    endcase
    if (out_load) begin
      out_item_q.hit_found    <= any_hit_q;
      out_item_q.hit_x        <= best_x_q;
      out_item_q.hit_y        <= best_y_q;
      out_item_q.hit_distance <= any_hit_q ? DIST_W'(ds_result[ROOT_W-1:0]) : '1;
    end
  end

  // Nearest hit of the current ray; the earlier segment wins a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sq_q <= '1;
      best_x_q  <= '0;
      best_y_q  <= '0;
      any_hit_q <= 1'b0;
    end else if (out_load) begin
      best_sq_q <= '1;
      best_x_q  <= '0;
      best_y_q  <= '0;
      any_hit_q <= 1'b0;
    end else if (state_q == ST_UPDATE && (!any_hit_q || dist_q < best_sq_q)) begin
      best_sq_q <= dist_q;
      best_x_q  <= hx_q;
      best_y_q  <= hy_q;
      any_hit_q <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  rsnh_divsqrt #(
    .NUM_W  (DEN_W),
    .Q_W    (T_FRAC_BITS),
    .ROOT_W (ROOT_W)
  ) u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ds_cmd),
    .num_i    (tnum_mag_q),
    .den_i    (den_mag_q),
    .rad_i    ((2 * ROOT_W)'(best_sq_q)),
    .stat_o   (ds_stat),
    .result_o (ds_result)
  );

  `RSNH_ASSERT_IMP(a_accept_unit_idle, in_valid_i && in_ready_o, !ds_stat.busy, "item taken while divsqrt busy")
  `RSNH_ASSERT_IMP(a_tq_in_range, state_q == ST_HIT_X, tq_q <= T_ONE, "t above one at hit point")
  `RSNH_ASSERT_IMP(a_no_hit_is_clear, !any_hit_q, best_sq_q == '1 && best_x_q == '0 && best_y_q == '0, "empty ray state not cleared")
  `RSNH_ASSERT_NXT(a_miss_result, out_load && !any_hit_q, out_item_q.hit_distance == '1 && !out_item_q.hit_found, "missed ray result not infinite")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: ray/segment nearest hit testbench
// Streams wall segments into the block and checks each per-ray result against
// an in-bench model: intersection test, nearest-hit bookkeeping, rounded hit
// point and integer root of the squared distance. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
  import rsnh_pkg::*;

  localparam int     DIR_FRAC     = 14;
  localparam int     T_FRAC       = 16;
  localparam longint UNIT         = 64'sd1 << DIR_FRAC;
  localparam longint T_HALF       = 64'sd1 << (T_FRAC - 1);
  localparam longint COORD_MAX    = (64'sd1 << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN    = -(64'sd1 << (COORD_W - 1));
  localparam longint THRESH_MAX   = (64'sd1 << THRESH_W) - 1;
  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_THRESHOLD + 1;
  localparam int     RAND_PHASES  = 19;
  localparam int     PHASE_ITEMS  = 100;
  localparam int     QUIET_PHASE  = 4;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     STALL_LIMIT  = 4000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  wall_item_t            in_item   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  hit_item_t             out_item;

  // handshakes seen at the last rising edge
  bit          in_fire, out_fire, cfg_fire;
  int unsigned idle_pct = 33;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned walls_pushed = 0;
  int unsigned walls_taken  = 0;

  wall_item_t pending_walls[$];
  hit_item_t  predicted_hits[$];

  // model copy of the ray registers
  logic signed [COORD_W-1:0]  org_x = '0;
  logic signed [COORD_W-1:0]  org_y = '0;
  logic signed [DIR_FRAC+1:0] dir_x = UNIT[DIR_FRAC+1:0];
  logic signed [DIR_FRAC+1:0] dir_y = '0;
  logic [THRESH_W-1:0]        thr   = THRESH_RESET;

  // nearest hit of the ray in progress
  bit              ray_hit  = 1'b0;
  longint unsigned best_dsq = '1;
  longint          best_x   = 0;
  longint          best_y   = 0;

  // ray as programmed, used to aim segments
  longint plan_ox = 0, plan_oy = 0, plan_dx = UNIT, plan_dy = 0;

  ray_segment_nearest_hit_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bit-by-bit integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // test one segment against the ray; a last segment yields the ray's result
  function automatic void cast_segment(input wall_item_t w);
    longint    ax, ay, bx, by, ox, oy, dx, dy, wx, wy, px, py;
    longint    den, tnum, cross_u, num_mag, den_mag, rem, tq, hx, hy;
    longint unsigned dsq, root;
    hit_item_t res;
    ax = w.wall_start_x;
    ay = w.wall_start_y;
    bx = w.wall_end_x;
    by = w.wall_end_y;
    ox = org_x;
    oy = org_y;
    dx = dir_x;
    dy = dir_y;
    wx = ax - bx;
    wy = ay - by;
    px = ax - ox;
    py = ay - oy;
    den     = dx * wy - dy * wx;
    tnum    = dx * py - dy * px;
    cross_u = px * wy - py * wx;
    num_mag = (tnum < 0) ? -tnum : tnum;
    den_mag = (den < 0) ? -den : den;
    // hit: not parallel, 0 <= t <= 1, u >= 0 (signs taken against den)
    if (den != 0 && den_mag >= longint'(thr) &&
        (tnum == 0 || (tnum < 0) == (den < 0)) && num_mag <= den_mag &&
        (cross_u == 0 || (cross_u < 0) == (den < 0))) begin
      if (num_mag == den_mag) begin
        tq = 64'sd1 << T_FRAC;
      end else begin
        tq  = 0;
        rem = num_mag;
        repeat (T_FRAC) begin
          rem = rem << 1;
          tq  = tq << 1;
          if (rem >= den_mag) begin
            rem -= den_mag;
            tq  |= 1;
          end
        end
      end
      // hit point rounded half up
      hx  = ax + ((tq * (bx - ax) + T_HALF) >>> T_FRAC);
      hy  = ay + ((tq * (by - ay) + T_HALF) >>> T_FRAC);
      dsq = (hx - ox) * (hx - ox) + (hy - oy) * (hy - oy);
      // strict compare keeps the earlier wall on a tie
      if (!ray_hit || dsq < best_dsq) begin
        ray_hit  = 1'b1;
        best_dsq = dsq;
        best_x   = hx;
        best_y   = hy;
      end
    end
    if (w.last_wall) begin
      if (ray_hit) begin
        root             = int_sqrt(best_dsq);
        res.hit_found    = 1'b1;
        res.hit_x        = best_x[COORD_W-1:0];
        res.hit_y        = best_y[COORD_W-1:0];
        res.hit_distance = (root > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : root[DIST_W-1:0];
      end else begin
        res              = '0;
        res.hit_distance = '1;
      end
      predicted_hits.push_back(res);
      ray_hit  = 1'b0;
      best_dsq = '1;
      best_x   = 0;
      best_y   = 0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [DIST_W-1:0] exp_v,
                                      input logic [DIST_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // monitor: handshakes, register copy, result check, prediction
  always @(posedge clk) begin
    hit_item_t exp_hit;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (in_fire || out_fire || cfg_fire) stall_cycles = 0;
    else if (rst_n) stall_cycles++;
    if (cfg_fire) begin
      case (cfg_index)
        CFG_ORIGIN_X:  org_x = cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y:  org_y = cfg_data[COORD_W-1:0];
        CFG_DIR_X:     dir_x = cfg_data[DIR_FRAC+1:0];
        CFG_DIR_Y:     dir_y = cfg_data[DIR_FRAC+1:0];
        CFG_THRESHOLD: thr   = cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
    if (out_fire) begin
      if (predicted_hits.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %h", $time, out_item);
        mismatch_cnt++;
      end else begin
        exp_hit = predicted_hits.pop_front();
        check_field("hit_found", exp_hit.hit_found, out_item.hit_found);
        check_field("hit_x", exp_hit.hit_x, out_item.hit_x);
        check_field("hit_y", exp_hit.hit_y, out_item.hit_y);
        check_field("hit_distance", exp_hit.hit_distance, out_item.hit_distance);
      end
    end
    if (in_fire) begin
      walls_taken++;
      cast_segment(in_item);
    end
  end

  // segment driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_walls.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item  <= pending_walls.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(99) >= idle_pct);
  end

  initial begin : watchdog
    do @(negedge clk); while (stall_cycles < STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_ray(input longint ox, oy, dx, dy, thr_v);
    write_reg(CFG_ORIGIN_X, ox[CFG_DATA_W-1:0]);
    write_reg(CFG_ORIGIN_Y, oy[CFG_DATA_W-1:0]);
    write_reg(CFG_DIR_X, dx[CFG_DATA_W-1:0]);
    write_reg(CFG_DIR_Y, dy[CFG_DATA_W-1:0]);
    write_reg(CFG_THRESHOLD, thr_v[CFG_DATA_W-1:0]);
    plan_ox = ox;
    plan_oy = oy;
    plan_dx = dx;
    plan_dy = dy;
  endtask

  task automatic push_wall(input longint ax, ay, bx, by, input bit last);
    wall_item_t w;
    w.wall_start_x = ax[COORD_W-1:0];
    w.wall_start_y = ay[COORD_W-1:0];
    w.wall_end_x   = bx[COORD_W-1:0];
    w.wall_end_y   = by[COORD_W-1:0];
    w.last_wall    = last;
    pending_walls.push_back(w);
    walls_pushed++;
  endtask

  function automatic longint rnd_span(input longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic longint to_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // segment crossing the ray line near a chosen point; crowded keeps it tiny
  task automatic push_aimed(input bit last, input bit crowded);
    longint s, hx, hy, ex, ey, fx, fy, q;
    if (crowded) begin
      hx = plan_ox + rnd_span(4);
      hy = plan_oy + rnd_span(4);
      ex = rnd_span(8);
      ey = rnd_span(8);
    end else begin
      s = longint'($urandom_range(1 << $urandom_range(20)));
      if ($urandom_range(9) == 0) s = -s;
      hx = plan_ox + ((plan_dx * s) >>> DIR_FRAC);
      hy = plan_oy + ((plan_dy * s) >>> DIR_FRAC);
      q  = $urandom_range(20);
      ex = rnd_span(64'sd1 << q);
      ey = rnd_span(64'sd1 << q);
    end
    q  = $urandom_range(16);
    fx = hx - ((ex * q) >>> 3);
    fy = hy - ((ey * q) >>> 3);
    if ($urandom_range(1))
      push_wall(to_coord(hx + ex), to_coord(hy + ey), to_coord(fx), to_coord(fy), last);
    else
      push_wall(to_coord(fx), to_coord(fy), to_coord(hx + ex), to_coord(hy + ey), last);
  endtask

  // hold the sender until every result is in, then let the block go idle
  task automatic settle();
    do @(negedge clk); while (walls_taken != walls_pushed || predicted_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic signed [15:0] r16;
    logic signed [23:0] r24;
    longint ox, oy, dx, dy, thr_v;
    int unsigned sent, ray_len, kind;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset ray: unit x direction from the origin
    push_wall(256, -256, 256, 256, 1'b1);
    push_wall(-256, -256, -256, 256, 1'b1);                    // behind the origin
    push_wall(0, 256, 512, 256, 1'b0);                         // parallel
    push_wall(512, 0, 512, 256, 1'b0);                         // t = 0
    push_wall(768, -256, 768, 0, 1'b0);                        // t = 1
    push_wall(0, -256, 0, 256, 1'b1);                          // through the origin
    push_wall(1024, -256, 1024, 256, 1'b0);                    // tie, first wins
    push_wall(1024, 256, 1024, -256, 1'b1);
    push_wall(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    push_wall(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1); // point segment
    settle();

    // zero threshold: exactly parallel still misses; spare index is ignored
    program_ray(0, 0, UNIT, 0, 0);
    write_reg(CFG_IDX_SPARE, '1);
    push_wall(0, 256, 512, 256, 1'b0);
    push_wall(256, -256, 256, 256, 1'b1);
    settle();

    // far corner to far corner, diagonal ray, largest threshold
    program_ray(COORD_MIN, COORD_MIN, 11585, 11585, THRESH_MAX);
    push_wall(COORD_MAX, 8388000, 8388000, COORD_MAX, 1'b1);
    settle();

    // direction extremes, origin at the top corner
    program_ray(COORD_MAX, COORD_MAX, -32768, 32767, THRESH_RESET);
    push_wall(0, 0, COORD_MAX, COORD_MIN, 1'b0);
    push_wall(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    settle();

    // zero direction never hits
    program_ray(0, 0, 0, 0, THRESH_RESET);
    push_wall(256, -256, 256, 256, 1'b1);
    settle();

    // random rays, each phase with its own ray setup
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_pct = (ph == QUIET_PHASE) ? 0 : 33;
      if ($urandom_range(3) == 0) begin
        r24 = $urandom();
        ox  = r24;
        r24 = $urandom();
        oy  = r24;
      end else begin
        ox = rnd_span(64'sd1 << 21);
        oy = rnd_span(64'sd1 << 21);
      end
      if ($urandom_range(3) == 0) begin
        r16 = $urandom();
        dx  = r16;
        r16 = $urandom();
        dy  = r16;
      end else begin
        dx = $urandom_range(UNIT);
        dy = int_sqrt(UNIT * UNIT - dx * dx);
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
      end
      case ($urandom_range(4))
        0:       thr_v = 0;
        1:       thr_v = $urandom_range(THRESH_MAX);
        default: thr_v = $urandom_range(64);
      endcase
      program_ray(ox, oy, dx, dy, thr_v);
      if ($urandom_range(3) == 0) write_reg(CFG_IDX_SPARE + $urandom_range(2), $urandom());

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        ray_len = $urandom_range(1, 6);
        for (int i = 0; i < ray_len; i++) begin
          kind = $urandom_range(99);
          if (kind < 70)      push_aimed(i == ray_len - 1, 1'b0);
          else if (kind < 85) push_aimed(i == ray_len - 1, 1'b1);
          else push_wall($urandom(), $urandom(), $urandom(), $urandom(), i == ray_len - 1);
        end
        sent += ray_len;
      end
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
